/* src/stkc_pkg.sv */
// Package for the streaming top-K cutoff unit: sizes, entry and link types,
// cell operation codes and the keep-count clamp.
// Used by stkc_cell and streaming_top_k_cutoff_unit; depends on nothing.
`default_nettype none

package stkc_pkg;

  localparam int MAX_KEEP = 32;
  localparam int KEEP_W   = 6;
  localparam int FILL_W   = $clog2(MAX_KEEP + 1);
  localparam int RANK_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int LEVEL_W  = 16;
  localparam int ID_W     = 16;
  localparam int COUNT_W  = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(32);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    id;
  } entry_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   ge;     // valid and level <= incoming level
  } cell_link_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_SHIFT   = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  localparam logic KIND_CUTOFF = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Clamp the written keep count into 1..MAX_KEEP.
  function automatic logic [KEEP_W-1:0] eff_keep(input logic [KEEP_W-1:0] raw);
    logic [KEEP_W-1:0] k;
    k = raw;
    if (k == '0) begin
      k = KEEP_W'(1);
    end
    if (k > KEEP_W'(MAX_KEEP)) begin
      k = KEEP_W'(MAX_KEEP);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/stkc_cell.sv */
// One cell of the sorted chain: holds one entry and its valid bit, and
// takes its next value from itself, a neighbor or the incoming player.
// Depends on stkc_pkg.
`default_nettype none

module stkc_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  stkc_pkg::cell_op_t       op,
  input  stkc_pkg::entry_t         new_entry,
  input  stkc_pkg::cell_link_t     left,
  input  stkc_pkg::cell_link_t     right,
  output stkc_pkg::cell_link_t     link
);

  stkc_pkg::entry_t entry_r, entry_nxt;
  logic             valid_r, valid_nxt;
  logic             ge;

  assign ge   = valid_r && (entry_r.level <= new_entry.level);
  assign link = '{entry: entry_r, valid: valid_r, ge: ge};

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (op)
      stkc_pkg::OP_HOLD: begin
      end
      stkc_pkg::OP_INSERT: begin
        // stay below the new player, take it, or move up from the left
        if (!ge) begin
          if (left.ge) begin
            entry_nxt = new_entry;
            valid_nxt = 1'b1;
          end else begin
            entry_nxt = left.entry;
            valid_nxt = left.valid;
          end
        end
      end
      stkc_pkg::OP_REPLACE: begin
        // lowest drops out: pull down from the right, or take the new player
        if (right.ge) begin
          entry_nxt = right.entry;
        end else if (ge) begin
          entry_nxt = new_entry;
        end
      end
      stkc_pkg::OP_SHIFT: begin
        entry_nxt = right.entry;
        valid_nxt = right.valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

/* src/streaming_top_k_cutoff_unit.sv */
// Top level of the streaming top-K cutoff unit: control, counters, output
// register and the chain of stkc_cell instances.
// Depends on stkc_pkg and stkc_cell.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   level, player_id, end_of_stream
//   out_     output     out_valid/out_stall kind, items_read, level_out, id_out,
//                                           final_res
//   cfg_     input      cfg_wr_en           cfg_wr_data (keep count)
//
// One player per cycle: all cells compare and shift in the same cycle, and
// outside a drain the single output register is the only limit, so a cutoff
// report that is not taken at once stalls the next player. An end-of-stream
// player starts a drain of every held entry (1..MAX_KEEP), with in_stall high.
// Synchronous active-low reset empties the chain and clears the counters;
// keep count resets to 32.
`default_nettype none

module streaming_top_k_cutoff_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [stkc_pkg::LEVEL_W-1:0]  in_level,
  input  wire logic [stkc_pkg::ID_W-1:0]     in_player_id,
  input  wire logic                          in_end_of_stream,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_kind,
  output      logic [stkc_pkg::COUNT_W-1:0]  out_items_read,
  output      logic [stkc_pkg::LEVEL_W-1:0]  out_level_out,
  output      logic [stkc_pkg::ID_W-1:0]     out_id_out,
  output      logic                          out_final_res,
  input  wire logic                          cfg_wr_en,
  input  wire logic [stkc_pkg::KEEP_W-1:0]   cfg_wr_data
);

  localparam int N = stkc_pkg::MAX_KEEP;

  stkc_pkg::state_t                 state_r, state_nxt;
  logic [stkc_pkg::KEEP_W-1:0]      keep_r;
  logic [stkc_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [stkc_pkg::COUNT_W-1:0]     total_r, total_nxt;
  logic [stkc_pkg::KEEP_W-1:0]      phase_r, phase_nxt, phase_inc;
  logic [stkc_pkg::RANK_W-1:0]      rank_r, rank_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_kind_r, out_kind_nxt;
  logic [stkc_pkg::COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [stkc_pkg::LEVEL_W-1:0]     out_lvl_r, out_lvl_nxt;
  logic [stkc_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic                             out_fin_r, out_fin_nxt;

  logic [stkc_pkg::KEEP_W-1:0]      k;
  logic                             slot_free, accept, drain_step, report, last_entry;
  logic [stkc_pkg::LEVEL_W-1:0]     cut_level;
  stkc_pkg::cell_op_t               op;
  stkc_pkg::entry_t                 new_entry;
  stkc_pkg::cell_link_t             lnk [N+1];
  stkc_pkg::cell_link_t             left_tie;
  logic [N-1:0]                     vld;
  logic                             sorted_ok;

  assign k          = stkc_pkg::eff_keep(keep_r);
  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == stkc_pkg::ST_RUN) && slot_free);
  assign accept     = in_valid && !in_stall;
  assign drain_step = (state_r == stkc_pkg::ST_DRAIN) && slot_free;
  assign last_entry = !lnk[1].valid;
  assign new_entry  = '{level: in_level, id: in_player_id};
  assign left_tie   = '{entry: '0, valid: 1'b1, ge: 1'b1};
  assign lnk[N]     = '0;
  assign phase_inc  = phase_r + stkc_pkg::KEEP_W'(1);
  assign report     = (phase_inc >= k);

  // choose what the chain does this cycle
  always_comb begin
    op = stkc_pkg::OP_HOLD;
    if (accept) begin
      if (stkc_pkg::KEEP_W'(fill_r) < k) begin
        op = stkc_pkg::OP_INSERT;
      end else if (in_level > lnk[0].entry.level) begin
        op = stkc_pkg::OP_REPLACE;
      end
    end else if (drain_step) begin
      op = stkc_pkg::OP_SHIFT;
    end
  end

  // lowest level after this player's update
  always_comb begin
    unique case (op)
      stkc_pkg::OP_INSERT:  cut_level = lnk[0].ge ? lnk[0].entry.level : in_level;
      stkc_pkg::OP_REPLACE: cut_level = lnk[1].ge ? lnk[1].entry.level : in_level;
      default:              cut_level = lnk[0].entry.level;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    stkc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .new_entry (new_entry),
      .left      ((i == 0) ? left_tie : lnk[(i == 0) ? 0 : i-1]),
      .right     (lnk[i+1]),
      .link      (lnk[i])
    );
    assign vld[i] = lnk[i].valid;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    phase_nxt     = phase_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_cnt_nxt   = out_cnt_r;
    out_lvl_nxt   = out_lvl_r;
    out_id_nxt    = out_id_r;
    out_fin_nxt   = out_fin_r;

    if (accept) begin
      if (total_r != '1) begin
        total_nxt = total_r + stkc_pkg::COUNT_W'(1);
      end
      if (op == stkc_pkg::OP_INSERT) begin
        fill_nxt = fill_r + stkc_pkg::FILL_W'(1);
      end
      phase_nxt = report ? '0 : phase_inc;
      if (report || in_end_of_stream) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = stkc_pkg::KIND_CUTOFF;
        out_cnt_nxt   = total_nxt;
        out_lvl_nxt   = cut_level;
        out_id_nxt    = '0;
        out_fin_nxt   = 1'b0;
      end
      if (in_end_of_stream) begin
        state_nxt = stkc_pkg::ST_DRAIN;
        fill_nxt  = '0;
        total_nxt = '0;
        phase_nxt = '0;
        rank_nxt  = '0;
      end
    end else if (drain_step) begin
      // emit the lowest cell and shift the chain down
      out_valid_nxt = 1'b1;
      out_kind_nxt  = stkc_pkg::KIND_ENTRY;
      out_cnt_nxt   = {{(stkc_pkg::COUNT_W-stkc_pkg::RANK_W){1'b0}}, rank_r};
      out_lvl_nxt   = lnk[0].entry.level;
      out_id_nxt    = lnk[0].entry.id;
      out_fin_nxt   = last_entry;
      rank_nxt      = rank_r + stkc_pkg::RANK_W'(1);
      if (last_entry) begin
        state_nxt = stkc_pkg::ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stkc_pkg::ST_RUN;
      keep_r      <= stkc_pkg::KEEP_RESET;
      fill_r      <= '0;
      total_r     <= '0;
      phase_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      phase_r     <= phase_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_id_r   <= out_id_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_items_read = out_cnt_r;
  assign out_level_out  = out_lvl_r;
  assign out_id_out     = out_id_r;
  assign out_final_res  = out_fin_r;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i + 1 < N; i++) begin
      if (lnk[i+1].valid && (lnk[i].entry.level > lnk[i+1].entry.level)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stkc_pkg::ST_RUN) |-> ($countones(vld) == int'(fill_r)))
    else $error("fill count disagrees with valid cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld & (vld + N'(1))) == '0))
    else $error("valid cells are not a contiguous run from cell 0");

  a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_ok)
    else $error("chain is not in ascending level order");

  a_final_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |-> (out_kind == stkc_pkg::KIND_ENTRY))
    else $error("final flag on a cutoff report");

  a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_step && last_entry) |=> (vld == '0))
    else $error("cells left after the last ranked entry");

endmodule

`default_nettype wire
